/* design/heightfield_triangle_interpolator_top_defines.svh */
// Assertion macros for the interpolator modules; only hti_ctrl uses them.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef HEIGHTFIELD_TRIANGLE_INTERPOLATOR_TOP_DEFINES_SVH
`define HEIGHTFIELD_TRIANGLE_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define HTI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hti_pkg.sv */
// Shared types for the heightfield triangle interpolator.
// Used by hti_ctrl, hti_dpath and the top level; no dependencies.
`timescale 1ns / 1ps

package hti_pkg;

    localparam int HEIGHT_MAX = 32767;
    localparam int DIVISOR    = 3;

    typedef enum logic [0:0] {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2,
        CORNER_D = 2'd3
    } corner_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_RD_D,
        S_CAP_D,
        S_MUL,
        S_SUM,
        S_DIV,
        S_FIX,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load_we;
        logic    query_latch;
        logic    rd_en;
        corner_t rd_corner;
        logic    cap_en;
        corner_t cap_corner;
        logic    mul_en;
        logic    sum_en;
        logic    div_en;
        logic    fix_en;
    } cmd_t;

    typedef struct packed {
        logic in_oor;
    } status_t;

endpackage

/* design/hti_ctrl.sv */
// Sequencer for the interpolator: accepts requests, steps corner reads and math.
// Depends on hti_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "heightfield_triangle_interpolator_top_defines.svh"

module hti_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             action,
    input  hti_pkg::status_t status,
    output hti_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    hti_pkg::state_t state_reg;
    hti_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hti_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_corner  = hti_pkg::CORNER_A;
        cmd.cap_corner = hti_pkg::CORNER_A;
        case (state_reg)
            hti_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (action == hti_pkg::ACT_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.query_latch = 1'b1;
                        state_next = status.in_oor ? hti_pkg::S_OUT : hti_pkg::S_RD_A;
                    end
                end
            end
            hti_pkg::S_RD_A:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = hti_pkg::CORNER_A;
                state_next    = hti_pkg::S_RD_B;
            end
            hti_pkg::S_RD_B:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = hti_pkg::CORNER_B;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = hti_pkg::CORNER_A;
                state_next     = hti_pkg::S_RD_C;
            end
            hti_pkg::S_RD_C:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = hti_pkg::CORNER_C;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = hti_pkg::CORNER_B;
                state_next     = hti_pkg::S_RD_D;
            end
            hti_pkg::S_RD_D:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = hti_pkg::CORNER_D;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = hti_pkg::CORNER_C;
                state_next     = hti_pkg::S_CAP_D;
            end
            hti_pkg::S_CAP_D:
            begin
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = hti_pkg::CORNER_D;
                state_next     = hti_pkg::S_MUL;
            end
            hti_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = hti_pkg::S_SUM;
            end
            hti_pkg::S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = hti_pkg::S_DIV;
            end
            hti_pkg::S_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = hti_pkg::S_FIX;
            end
            hti_pkg::S_FIX:
            begin
                cmd.fix_en = 1'b1;
                state_next = hti_pkg::S_OUT;
            end
            hti_pkg::S_OUT:
            begin
                state_next = hti_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hti_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != hti_pkg::S_IDLE);
    assign done = (state_reg == hti_pkg::S_OUT);

    `HTI_ASSERT_NXT(a_query_busy, start && !busy && action == hti_pkg::ACT_QUERY, busy,
        "query request not followed by busy")
    `HTI_ASSERT_NXT(a_load_idle, start && !busy && action == hti_pkg::ACT_LOAD, !busy && !done,
        "load request left block busy or produced a result")
    `HTI_ASSERT_NXT(a_oor_fast, start && !busy && action == hti_pkg::ACT_QUERY && status.in_oor,
        done, "out-of-range query did not finish next cycle")
    `HTI_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `HTI_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")

endmodule

/* design/hti_dpath.sv */
// Datapath: height grid memory, corner registers, interpolation and divide by three.
// Depends on hti_pkg; driven by commands from hti_ctrl.
`timescale 1ns / 1ps

module hti_dpath
#(
    parameter int GRID_CELLS = 256,
    parameter int FRAC_BITS  = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hti_pkg::cmd_t    cmd,
    output hti_pkg::status_t status,
    input  logic [8:0]       grid_x,
    input  logic [8:0]       grid_z,
    input  logic [7:0]       sample,
    input  logic [16:0]      query_x,
    input  logic [16:0]      query_z,
    output logic [14:0]      height,
    output logic             out_of_range
);

    localparam int GRID_SIDE = GRID_CELLS + 1;
    localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(GRID_SIDE);
    localparam int FIX_ONE   = 1 << FRAC_BITS;
    localparam int LIMIT     = GRID_CELLS * FIX_ONE;
    localparam int FW        = FRAC_BITS + 1;        // fraction incl. value ONE
    localparam int PRW       = 9 + FW + 1;           // signed diff times weight
    localparam int HSW       = PRW + 2;              // signed sum
    localparam int HW        = 8 + FRAC_BITS;        // unsigned height before divide
    localparam logic [HW-1:0] RECIP = HW'((1 << HW) / hti_pkg::DIVISOR);

    logic [7:0] mem [DEPTH];

    logic [CW-1:0]  ix_reg, iz_reg, ix_next, iz_next;
    logic [FW-1:0]  dx_reg, dz_reg, dx_next, dz_next;
    logic [7:0]     mem_q_reg;
    logic [7:0]     a_reg, b_reg, c_reg, d_reg;
    logic signed [PRW-1:0] p1_reg, p2_reg, p1_next, p2_next;
    logic [7:0]     base_reg, base_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [HW-1:0]  q0_reg, q0_next;
    logic [14:0]    height_reg, height_next;
    logic           oor_reg;

    logic [CW-1:0]  ax, az;
    logic [AW-1:0]  addr;
    logic           in_grid;

    // query split with saturation at the far edge
    always_comb
    begin
        status.in_oor = query_x[16] | query_z[16];
        if (int'(query_x[15:0]) >= LIMIT)
        begin
            ix_next = CW'(GRID_CELLS - 1);
            dx_next = FW'(FIX_ONE);
        end
        else
        begin
            ix_next = CW'(query_x[15:0] >> FRAC_BITS);
            dx_next = {1'b0, query_x[FRAC_BITS-1:0]};
        end
        if (int'(query_z[15:0]) >= LIMIT)
        begin
            iz_next = CW'(GRID_CELLS - 1);
            dz_next = FW'(FIX_ONE);
        end
        else
        begin
            iz_next = CW'(query_z[15:0] >> FRAC_BITS);
            dz_next = {1'b0, query_z[FRAC_BITS-1:0]};
        end
    end

    // shared address: load coordinates or the selected corner
    always_comb
    begin
        in_grid = (int'(grid_x) <= GRID_CELLS) && (int'(grid_z) <= GRID_CELLS);
        if (cmd.load_we)
        begin
            ax = CW'(grid_x);
            az = CW'(grid_z);
        end
        else
        begin
            ax = ix_reg;
            az = iz_reg;
            case (cmd.rd_corner)
                hti_pkg::CORNER_A: ;
                hti_pkg::CORNER_B: az = iz_reg + 1'b1;
                hti_pkg::CORNER_C: ax = ix_reg + 1'b1;
                hti_pkg::CORNER_D:
                begin
                    ax = ix_reg + 1'b1;
                    az = iz_reg + 1'b1;
                end
                default: ;
            endcase
        end
        addr = AW'(ax) * AW'(GRID_SIDE) + AW'(az);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && in_grid)
        begin
            mem[addr] <= sample;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    // triangle select, weighted differences, sum, divide by three and clamp
    logic                 lower;
    logic [FW-1:0]        w1, w2;
    logic [7:0]           e1, e2;
    logic signed [8:0]    df1, df2;
    logic signed [FW:0]   w1s, w2s;
    logic signed [HSW-1:0] h_sum;
    logic [2*HW-1:0]      prod;
    logic [HW+1:0]        rem;
    logic [HW-1:0]        q;

    always_comb
    begin
        lower = int'((FW + 1)'(dx_reg) + (FW + 1)'(dz_reg)) < FIX_ONE;
        if (lower)
        begin
            base_next = a_reg;
            e1 = c_reg;
            w1 = dx_reg;
            e2 = b_reg;
            w2 = dz_reg;
        end
        else
        begin
            base_next = d_reg;
            e1 = b_reg;
            w1 = FW'(FIX_ONE) - dx_reg;
            e2 = c_reg;
            w2 = FW'(FIX_ONE) - dz_reg;
        end
        df1 = $signed({1'b0, e1}) - $signed({1'b0, base_next});
        df2 = $signed({1'b0, e2}) - $signed({1'b0, base_next});
        w1s = $signed({1'b0, w1});
        w2s = $signed({1'b0, w2});
        p1_next = PRW'(df1) * PRW'(w1s);
        p2_next = PRW'(df2) * PRW'(w2s);

        h_sum = HSW'($signed({1'b0, base_reg, FRAC_BITS'(0)})) + HSW'(p1_reg) + HSW'(p2_reg);
        h_next = h_sum[HSW-1] ? '0 : HW'(h_sum);

        // reciprocal estimate is exact or one low
        prod = (2 * HW)'(h_reg) * (2 * HW)'(RECIP);
        q0_next = prod[2*HW-1:HW];

        rem = (HW + 2)'(h_reg) - (HW + 2)'(q0_reg) * (HW + 2)'(hti_pkg::DIVISOR);
        q = (int'(rem) >= hti_pkg::DIVISOR) ? q0_reg + 1'b1 : q0_reg;
        height_next = (int'(q) > hti_pkg::HEIGHT_MAX) ? 15'(hti_pkg::HEIGHT_MAX) : 15'(q);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_latch)
        begin
            ix_reg <= ix_next;
            iz_reg <= iz_next;
            dx_reg <= dx_next;
            dz_reg <= dz_next;
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_corner)
                hti_pkg::CORNER_A: a_reg <= mem_q_reg;
                hti_pkg::CORNER_B: b_reg <= mem_q_reg;
                hti_pkg::CORNER_C: c_reg <= mem_q_reg;
                hti_pkg::CORNER_D: d_reg <= mem_q_reg;
                default: ;
            endcase
        end
        if (cmd.mul_en)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            base_reg <= base_next;
        end
        if (cmd.sum_en)
        begin
            h_reg <= h_next;
        end
        if (cmd.div_en)
        begin
            q0_reg <= q0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg    <= 1'b0;
            height_reg <= '0;
        end
        else
        begin
            if (cmd.query_latch)
            begin
                oor_reg <= status.in_oor;
                if (status.in_oor)
                begin
                    height_reg <= '0;
                end
            end
            if (cmd.fix_en)
            begin
                height_reg <= height_next;
            end
        end
    end

    assign height       = height_reg;
    assign out_of_range = oor_reg;

endmodule

/* design/heightfield_triangle_interpolator_top.sv */
// Heightfield triangle interpolator. Query: four serial corner reads from one memory
// port, then multiply, sum, reciprocal multiply and correction; done pulses at the end
// and busy holds off a new request until after it. Out-of-range query: done next
// cycle, busy until it has gone. Load: no result, block stays idle. Results cannot stall.
// Reset clears the sequencer and output flags; the grid is undefined until written.
`timescale 1ns / 1ps

module heightfield_triangle_interpolator_top
#(
    parameter int GRID_CELLS = 256,
    parameter int FRAC_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [8:0]  grid_x,
    input  logic [8:0]  grid_z,
    input  logic [7:0]  sample,
    input  logic [16:0] query_x,
    input  logic [16:0] query_z,
    output logic        done,
    output logic [14:0] height,
    output logic        out_of_range
);

    hti_pkg::cmd_t    cmd;
    hti_pkg::status_t status;
    logic             ctrl_busy;

    hti_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy),
        .done   (done)
    );

    hti_dpath
    #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .grid_x       (grid_x),
        .grid_z       (grid_z),
        .sample       (sample),
        .query_x      (query_x),
        .query_z      (query_z),
        .height       (height),
        .out_of_range (out_of_range)
    );

    assign busy = ctrl_busy;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for heightfield_triangle_interpolator_top.
// Needs hti_pkg and the top-level RTL. Mirrors the height grid, predicts each query
// result or takes the directed expectation, and checks it against the done strobe.

module tb_top;

    localparam int     GRID_CELLS   = 256;
    localparam int     FRAC_BITS    = 8;
    localparam int     SIDE         = GRID_CELLS + 1;
    localparam longint ONE          = longint'(1) << FRAC_BITS;
    localparam int     NUM_REQUESTS = 800;
    localparam int     CALM_TAIL    = 100;
    localparam int     WIN_CELLS    = 8;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 20;

    localparam hti_pkg::action_t LD = hti_pkg::ACT_LOAD;
    localparam hti_pkg::action_t QR = hti_pkg::ACT_QUERY;

    typedef struct packed {
        logic [14:0] height;
        logic        oor;
    } height_res_t;

    typedef struct packed {
        hti_pkg::action_t act;
        logic [8:0]  gx;
        logic [8:0]  gz;
        logic [7:0]  smp;
        logic [16:0] qx;
        logic [16:0] qz;
        logic        has_exp;
        logic [14:0] exp_h;
        logic        exp_oor;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    hti_pkg::action_t action;
    logic [8:0]       grid_x;
    logic [8:0]       grid_z;
    logic [7:0]       sample;
    logic [16:0]      query_x;
    logic [16:0]      query_z;
    logic             done;
    logic [14:0]      height;
    logic             out_of_range;

    logic [7:0]  height_mirror [0:SIDE*SIDE-1];
    bit          sample_loaded [0:SIDE*SIDE-1];
    height_res_t pending_heights [$];
    dir_row_t    dir_rows [0:24];

    int errors    = 0;
    int n_sent    = 0;
    int n_loads   = 0;
    int n_queries = 0;
    int n_oor     = 0;
    int n_checked = 0;
    bit idle_on   = 1'b1;

    heightfield_triangle_interpolator_top #(
        .GRID_CELLS(GRID_CELLS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .grid_x      (grid_x),
        .grid_z      (grid_z),
        .sample      (sample),
        .query_x     (query_x),
        .query_z     (query_z),
        .done        (done),
        .height      (height),
        .out_of_range(out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // clamp a non-negative position, split into cell index and fraction (0..ONE)
    function automatic void split_pos(input longint raw, output longint idx,
                                      output longint frac);
        longint p;
        longint c;
        p = raw;
        if (p > GRID_CELLS * ONE)
            p = GRID_CELLS * ONE;
        c = p >>> FRAC_BITS;
        if (c > GRID_CELLS - 1)
            c = GRID_CELLS - 1;
        idx  = c;
        frac = p - c * ONE;
    endfunction

    // updates the grid mirror on loads; returns 1 when the request yields a result
    function automatic bit predict_height(input hti_pkg::action_t act, input logic [8:0] gx,
                                          input logic [8:0] gz, input logic [7:0] smp,
                                          input logic [16:0] qx, input logic [16:0] qz,
                                          output height_res_t res);
        longint ix, iz, fx, fz, a, b, c, d, h;
        res = '0;
        if (act == hti_pkg::ACT_LOAD)
        begin
            if (gx <= GRID_CELLS && gz <= GRID_CELLS)
            begin
                height_mirror[int'(gx) * SIDE + int'(gz)] = smp;
                sample_loaded[int'(gx) * SIDE + int'(gz)] = 1'b1;
            end
            return 1'b0;
        end
        if (qx[16] || qz[16])
        begin
            res.oor = 1'b1;
            return 1'b1;
        end
        split_pos(longint'(qx), ix, fx);
        split_pos(longint'(qz), iz, fz);
        a = longint'(height_mirror[ix * SIDE + iz]);
        b = longint'(height_mirror[ix * SIDE + iz + 1]);
        c = longint'(height_mirror[(ix + 1) * SIDE + iz]);
        d = longint'(height_mirror[(ix + 1) * SIDE + iz + 1]);
        // lower triangle anchors on A, upper on D; x weight follows the x neighbor
        if (fx + fz < ONE)
            h = a * ONE + (c - a) * fx + (b - a) * fz;
        else
            h = d * ONE + (b - d) * (ONE - fx) + (c - d) * (ONE - fz);
        if (h < 0)
            h = 0;
        h = h / hti_pkg::DIVISOR;
        if (h > hti_pkg::HEIGHT_MAX)
            h = hti_pkg::HEIGHT_MAX;
        res.height = h[14:0];
        return 1'b1;
    endfunction

    // called at a falling edge; returns at a falling edge after the request is taken
    task automatic issue(input hti_pkg::action_t act, input logic [8:0] gx,
                         input logic [8:0] gz,
                         input logic [7:0] smp, input logic [16:0] qx,
                         input logic [16:0] qz, input bit has_exp,
                         input height_res_t exp_res);
        height_res_t res;
        start   <= 1'b1;
        action  <= act;
        grid_x  <= gx;
        grid_z  <= gz;
        sample  <= smp;
        query_x <= qx;
        query_z <= qz;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
        if (predict_height(act, gx, gz, smp, qx, qz, res))
        begin
            pending_heights.push_back(has_exp ? exp_res : res);
            n_queries++;
            if (res.oor)
                n_oor++;
        end
        else
            n_loads++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // load any unwritten corner of the cell first, then send the query
    task automatic query_with_corners(input logic [16:0] qx, input logic [16:0] qz);
        longint ix, iz, fx, fz;
        int     cx, cz;
        split_pos(longint'(qx), ix, fx);
        split_pos(longint'(qz), iz, fz);
        for (int k = 0; k < 4; k++)
        begin
            cx = int'(ix) + (k >> 1);
            cz = int'(iz) + (k & 1);
            if (!sample_loaded[cx * SIDE + cz])
                issue(hti_pkg::ACT_LOAD, cx[8:0], cz[8:0], 8'($urandom_range(0, 255)),
                      17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h1FFFF)),
                      1'b0, '0);
        end
        issue(hti_pkg::ACT_QUERY, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
              8'($urandom_range(0, 255)), qx, qz, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        height_res_t want;
        if (rst_n && done)
        begin
            if (pending_heights.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending: height=%0d oor=%0b",
                         $time, height, out_of_range);
            end
            else
            begin
                want = pending_heights.pop_front();
                n_checked++;
                if (height !== want.height)
                begin
                    errors++;
                    $display("%0t: height mismatch: expected %0d, actual %0d",
                             $time, want.height, height);
                end
                if (out_of_range !== want.oor)
                begin
                    errors++;
                    $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                             $time, want.oor, out_of_range);
                end
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a result out
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        height_res_t exp_res;
        logic [16:0] qx, qz;
        int          pick;
        bit          paused;

        dir_rows = '{
            '{LD, 9'd0,   9'd0,   8'd255, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd0,   9'd1,   8'd255, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd1,   9'd0,   8'd255, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd1,   9'd1,   8'd255, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00000, 17'h00000, 1'b1, 15'd21760, 1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h000FF, 17'h000FF, 1'b1, 15'd21760, 1'b0},
            // negative on one axis only
            '{QR, 9'd0,   9'd0,   8'd0,   17'h10000, 17'h00000, 1'b1, 15'd0,     1'b1},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00000, 17'h1FFFF, 1'b1, 15'd0,     1'b1},
            '{LD, 9'd255, 9'd255, 8'd0,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd255, 9'd256, 8'd0,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd256, 9'd255, 8'd0,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd256, 9'd256, 8'd0,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h0FFFF, 17'h0FFFF, 1'b1, 15'd0,     1'b0},
            // loads off the grid must leave the store alone
            '{LD, 9'd511, 9'd0,   8'd170, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd0,   9'd257, 8'd85,  17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd257, 9'd256, 8'd1,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00000, 17'h00000, 1'b1, 15'd21760, 1'b0},
            '{LD, 9'd10,  9'd20,  8'd0,   17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd10,  9'd21,  8'd100, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd11,  9'd20,  8'd200, 17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{LD, 9'd11,  9'd21,  8'd50,  17'h00000, 17'h00000, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00A80, 17'h01440, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00AC8, 17'h01464, 1'b0, 15'd0,     1'b0},
            // dx + dz exactly one: upper triangle
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00A80, 17'h01480, 1'b0, 15'd0,     1'b0},
            '{QR, 9'd0,   9'd0,   8'd0,   17'h00A00, 17'h01400, 1'b0, 15'd0,     1'b0}
        };

        rst_n   = 1'b0;
        start   = 1'b0;
        action  = hti_pkg::ACT_LOAD;
        grid_x  = '0;
        grid_z  = '0;
        sample  = '0;
        query_x = '0;
        query_z = '0;
        paused  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            exp_res.height = dir_rows[i].exp_h;
            exp_res.oor    = dir_rows[i].exp_oor;
            issue(dir_rows[i].act, dir_rows[i].gx, dir_rows[i].gz, dir_rows[i].smp,
                  dir_rows[i].qx, dir_rows[i].qz, dir_rows[i].has_exp, exp_res);
        end

        while (n_sent < NUM_REQUESTS)
        begin
            if ($urandom_range(0, 47) == 0)
                idle_on = !idle_on;
            if (n_sent >= NUM_REQUESTS - CALM_TAIL)
                idle_on = 1'b0;
            if (!paused && n_sent >= NUM_REQUESTS / 2)
            begin
                // hold off until the block has returned everything
                paused = 1'b1;
                start <= 1'b0;
                do
                    @(negedge clk);
                while (pending_heights.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                query_with_corners(17'($urandom_range(0, WIN_CELLS * 256 - 1)),
                                   17'($urandom_range(0, WIN_CELLS * 256 - 1)));
            else if (pick < 55)
                query_with_corners(17'($urandom_range(0, 17'h0FFFF)),
                                   17'($urandom_range(0, 17'h0FFFF)));
            else if (pick < 65)
            begin
                qx = 17'($urandom_range(0, 17'h1FFFF));
                qz = 17'($urandom_range(0, 17'h1FFFF));
                case ($urandom_range(0, 2))
                    0: qx[16] = 1'b1;
                    1: qz[16] = 1'b1;
                    default:
                    begin
                        qx[16] = 1'b1;
                        qz[16] = 1'b1;
                    end
                endcase
                issue(hti_pkg::ACT_QUERY, 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                      qx, qz, 1'b0, '0);
            end
            else if (pick < 90)
                issue(hti_pkg::ACT_LOAD, 9'($urandom_range(0, WIN_CELLS)),
                      9'($urandom_range(0, WIN_CELLS)), 8'($urandom_range(0, 255)),
                      17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h1FFFF)),
                      1'b0, '0);
            else
                issue(hti_pkg::ACT_LOAD, 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                      17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h1FFFF)),
                      1'b0, '0);
        end

        start <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d grid loads, %0d queries (%0d with a negative axis).",
                 n_sent, n_loads, n_queries, n_oor);
        $display("Checked %0d results against the grid mirror, %0d errors.", n_checked, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/hti_pkg.sv
design/hti_ctrl.sv
design/hti_dpath.sv
design/heightfield_triangle_interpolator_top.sv
tb/tb_top.sv
